// File: hdl/cbc_pkg.sv
package cbc_pkg;

  // Controller kinds held in the configuration register
  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_MBC1 = 3'd1;
  localparam logic [2:0] KIND_MBC2 = 3'd2;
  localparam logic [2:0] KIND_MBC3 = 3'd3;
  localparam logic [2:0] KIND_MBC5 = 3'd4;

  // Result target classes
  localparam logic [2:0] TGT_ROM     = 3'd0;
  localparam logic [2:0] TGT_RAM     = 3'd1;
  localparam logic [2:0] TGT_CLOCK   = 3'd2;
  localparam logic [2:0] TGT_OPEN    = 3'd3;
  localparam logic [2:0] TGT_CONTROL = 3'd4;
  localparam logic [2:0] TGT_OUTSIDE = 3'd5;

  // Access commands
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam int unsigned ROM_BANK_BYTES = 16384;
  localparam int unsigned RAM_BANK_BYTES = 8192;

  localparam logic [8:0] ROM_BANK_RESET = 9'd1;

  typedef struct packed {
    logic [8:0] rom_bank;
    logic [3:0] ram_bank;
    logic       ram_enabled;
    logic       ram_banking_mode;
    logic       clock_selected;
    logic [2:0] clock_register_select;
  } bank_state_t;

  typedef struct packed {
    logic        command;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
  } access_t;

  typedef struct packed {
    logic [2:0]  target;
    logic [22:0] byte_offset;
    logic [2:0]  clock_index;
  } result_t;

endpackage

// File: hdl/cbc_if.sv
interface cbc_access_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] bus_address;
  logic [7:0]  write_data;

  modport source (output valid, output command, output bus_address, output write_data,
                  input ready);
  modport sink (input valid, input command, input bus_address, input write_data,
                output ready);
endinterface

interface cbc_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  target;
  logic [22:0] byte_offset;
  logic [2:0]  clock_index;

  modport source (output valid, output target, output byte_offset, output clock_index,
                  input ready);
  modport sink (input valid, input target, input byte_offset, input clock_index,
                output ready);
endinterface

interface cbc_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] controller_kind;

  modport source (output valid, output controller_kind, input ready);
  modport sink (input valid, input controller_kind, output ready);
endinterface

// File: hdl/cartridge_bank_controller.sv
// Cartridge bank controller: decodes one CPU bus access per beat on in_bus into a
// target class with a ROM/RAM byte offset or a clock register index on out_res, and
// applies control writes (0000-7FFF) to the bank registers under the controller kind
// set through cfg_wr. Throughput is one beat per cycle unless out_res stalls;
// an input register and a result register sit around a single decode pass. The input
// register keeps accepting while a result waits, so one beat is absorbed during an
// output stall. Each result reflects the bank state left by all earlier beats.
module cartridge_bank_controller
  import cbc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  cbc_access_if.sink   in_bus,
  cbc_result_if.source out_res,
  cbc_cfg_if.sink      cfg_wr
);

  logic        kind_r;
  logic [2:0]  ctrl_kind_r;
  logic        s1_v_r;
  logic        s1_v_nxt;
  access_t     s1_r;
  logic        out_v_r;
  logic        out_v_nxt;
  result_t     out_r;
  result_t     res;
  bank_state_t bank_state;
  logic        advance;
  logic        in_acc;
  logic        ctrl_wr;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_kind_r <= KIND_NONE;
      kind_r      <= 1'b0;
    end else if (cfg_wr.valid) begin
      ctrl_kind_r <= cfg_wr.controller_kind;
      kind_r      <= 1'b1;
    end
  end

  assign advance      = s1_v_r && (!out_v_r || out_res.ready);
  assign in_bus.ready = !s1_v_r || advance;
  assign in_acc       = in_bus.valid && in_bus.ready;
  assign s1_v_nxt     = in_acc || (s1_v_r && !advance);
  assign out_v_nxt    = advance || (out_v_r && !out_res.ready);
  assign ctrl_wr      = advance && (s1_r.command == CMD_WRITE) && !s1_r.bus_address[15];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // hold payloads while their stage stalls
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r.command     <= in_bus.command;
      s1_r.bus_address <= in_bus.bus_address;
      s1_r.write_data  <= in_bus.write_data;
    end
    if (advance) begin
      out_r <= res;
    end
  end

  cbc_bank_regs u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (ctrl_wr && (kind_r || ctrl_kind_r == KIND_NONE)),
    .kind  (ctrl_kind_r),
    .addr  (s1_r.bus_address),
    .data  (s1_r.write_data),
    .state (bank_state)
  );

  cbc_decode u_decode (
    .acc   (s1_r),
    .state (bank_state),
    .res   (res)
  );

  assign out_res.valid       = out_v_r;
  assign out_res.target      = out_r.target;
  assign out_res.byte_offset = out_r.byte_offset;
  assign out_res.clock_index = out_r.clock_index;

endmodule

// File: hdl/cbc_bank_regs.sv
module cbc_bank_regs
  import cbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [2:0]  kind,
  input  logic [15:0] addr,
  input  logic [7:0]  data,
  output bank_state_t state
);

  bank_state_t state_r;
  bank_state_t state_nxt;

  always_comb begin
    logic [8:0] rb;
    rb = state_r.rom_bank;
    state_nxt = state_r;
    case (kind)
      KIND_MBC1: begin
        if (addr[14:13] == 2'd0) begin
          state_nxt.ram_enabled = (data & 8'h0A) != 8'd0;
        end else if (addr[14:13] == 2'd1) begin
          rb = {2'b00, state_r.rom_bank[6:5], data[4:0]};
          if (rb[4:0] == 5'd0) rb[0] = 1'b1;
          state_nxt.rom_bank = rb;
        end else if (addr[14:13] == 2'd2) begin
          if (!state_r.ram_banking_mode) begin
            rb = {2'b00, data[1:0], state_r.rom_bank[4:0]};
            if (rb[4:0] == 5'd0) rb[0] = 1'b1;
            state_nxt.rom_bank = rb;
          end else if (data <= 8'h03) begin
            state_nxt.ram_bank = data[3:0];
          end
        end else begin
          state_nxt.ram_banking_mode = data != 8'd0;
        end
      end
      KIND_MBC2: begin
        if (addr[14:13] == 2'd0) begin
          if (!addr[8]) state_nxt.ram_enabled = !state_r.ram_enabled;
        end else if (addr[14:13] == 2'd1) begin
          if (addr[8]) begin
            state_nxt.rom_bank = (data[3:0] == 4'd0) ? 9'd1 : {5'd0, data[3:0]};
          end
        end
      end
      KIND_MBC3: begin
        if (addr[14:13] == 2'd0) begin
          state_nxt.ram_enabled = (data & 8'h0A) != 8'd0;
        end else if (addr[14:13] == 2'd1) begin
          state_nxt.rom_bank = (data[6:0] == 7'd0) ? 9'd1 : {2'd0, data[6:0]};
        end else if (addr[14:13] == 2'd2) begin
          if (data <= 8'h03) begin
            state_nxt.clock_selected = 1'b0;
            state_nxt.ram_bank       = data[3:0];
          end else if (data >= 8'h08 && data <= 8'h0C) begin
            state_nxt.clock_selected        = 1'b1;
            state_nxt.clock_register_select = 3'(data - 8'h08);
          end
        end
      end
      KIND_MBC5: begin
        if (addr[14:13] == 2'd0) begin
          state_nxt.ram_enabled = (data & 8'h0A) != 8'd0;
        end else if (addr[14:12] == 3'd2) begin
          state_nxt.rom_bank = {state_r.rom_bank[8], data};
        end else if (addr[14:12] == 3'd3) begin
          state_nxt.rom_bank = {data[0], state_r.rom_bank[7:0]};
        end else if (addr[14:13] == 2'd2) begin
          if (data <= 8'h0F) state_nxt.ram_bank = data[3:0];
        end
      end
      default: begin
        state_nxt = state_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.rom_bank              <= ROM_BANK_RESET;
      state_r.ram_bank              <= 4'd0;
      state_r.ram_enabled           <= 1'b0;
      state_r.ram_banking_mode      <= 1'b0;
      state_r.clock_selected        <= 1'b0;
      state_r.clock_register_select <= 3'd0;
    end else if (wr_en) begin
      state_r <= state_nxt;
    end
  end

  assign state = state_r;

endmodule

// File: hdl/cbc_decode.sv
module cbc_decode
  import cbc_pkg::*;
(
  input  access_t     acc,
  input  bank_state_t state,
  output result_t     res
);

  logic [22:0] rom_base;
  logic [22:0] ram_base;

  assign rom_base = 23'(state.rom_bank) * 23'(ROM_BANK_BYTES);
  assign ram_base = 23'(state.ram_bank) * 23'(RAM_BANK_BYTES);

  always_comb begin
    res.target      = TGT_OUTSIDE;
    res.byte_offset = 23'd0;
    res.clock_index = 3'd0;
    if (!acc.bus_address[15]) begin
      if (acc.command == CMD_WRITE) begin
        res.target = TGT_CONTROL;
      end else if (!acc.bus_address[14]) begin
        res.target      = TGT_ROM;
        res.byte_offset = 23'(acc.bus_address);
      end else begin
        res.target      = TGT_ROM;
        res.byte_offset = rom_base + 23'(acc.bus_address[13:0]);
      end
    end else if (acc.bus_address[15:13] == 3'b101) begin
      if (!state.ram_enabled) begin
        res.target = TGT_OPEN;
      end else if (state.clock_selected) begin
        res.target      = TGT_CLOCK;
        res.clock_index = state.clock_register_select;
      end else begin
        res.target      = TGT_RAM;
        res.byte_offset = ram_base + 23'(acc.bus_address[12:0]);
      end
    end
  end

endmodule

// File: hdl/cbc_checker.sv
module cbc_checker
  import cbc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_target,
  input logic [22:0] out_byte_offset,
  input logic [2:0]  out_clock_index
);

  // a stalled result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_idx_only_clock: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_target != TGT_CLOCK |-> out_clock_index == 3'd0)
    else $error("clock index set on a non-clock result");

  a_offset_only_mem: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_target == TGT_CLOCK || out_target == TGT_OPEN ||
                  out_target == TGT_CONTROL || out_target == TGT_OUTSIDE)
    |-> out_byte_offset == 23'd0)
    else $error("byte offset set on a non-memory result");

  a_target_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_target <= TGT_OUTSIDE)
    else $error("target code out of range");

endmodule

bind cartridge_bank_controller cbc_checker u_cbc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_res.valid),
  .out_ready       (out_res.ready),
  .out_target      (out_res.target),
  .out_byte_offset (out_res.byte_offset),
  .out_clock_index (out_res.clock_index)
);
